// ----- hw/rtl/raw_block_bit_unpacker_defines.svh -----
// assertion macros shared by the raw block unpacker modules
`ifndef RAW_BLOCK_BIT_UNPACKER_DEFINES_SVH
`define RAW_BLOCK_BIT_UNPACKER_DEFINES_SVH

// plain clocked assertion, held off during reset
`define RBU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define RBU_ASSERT_IMP(label, ante, cons, msg) \
  `RBU_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define RBU_ASSERT_NXT(label, ante, cons, msg) \
  `RBU_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- hw/rtl/rbu_pkg.sv -----
// types, constants and unpacking functions of the raw block unpacker
package rbu_pkg;

  localparam int unsigned BlockSamples = 64;
  localparam int unsigned StoreDepth   = 128;
  localparam int unsigned AddrW        = 7;

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_RD0  = 6'b000010,
    ST_RD1  = 6'b000100,
    ST_RD2  = 6'b001000,
    ST_SUM  = 6'b010000,
    ST_PUT  = 6'b100000
  } rbu_state_t;

  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  typedef struct packed {
    logic       accept;
    logic [1:0] rd_phase;
    logic       cap0;
    logic       cap1;
    logic       sum_en;
    logic       out_load;
    logic       next_sample;
  } rbu_cmd_t;

  typedef struct packed {
    logic emit_go;
    logic out_free;
    logic last_sample;
  } rbu_status_t;

  function automatic logic [7:0] code_len(input logic [3:0] code);
    logic [7:0] len;
    case (code)
      4'd0:    len = 8'd0;
      4'd1:    len = 8'd8;
      4'd2:    len = 8'd16;
      4'd3:    len = 8'd24;
      4'd4:    len = 8'd32;
      4'd5:    len = 8'd40;
      4'd6:    len = 8'd48;
      4'd7:    len = 8'd64;
      4'd8:    len = 8'd64;
      4'd9:    len = 8'd80;
      4'd10:   len = 8'd80;
      default: len = 8'd128;
    endcase
    return len;
  endfunction

  // store address of the j-th byte that feeds sample s
  function automatic logic [6:0] sample_addr(input logic [3:0] code, input logic [5:0] s,
                                             input logic [1:0] j);
    logic [2:0] g;
    logic [2:0] i;
    logic [3:0] row;
    logic [6:0] a;
    g   = s[5:3];
    i   = s[2:0];
    row = 4'd0;
    a   = 7'd0;
    case (code)
      4'd0: a = 7'd0;
      4'd1: a = {4'd0, g};
      4'd2: a = {3'd0, g[2], i};
      4'd3: a = {2'd0, j, i};
      4'd4: a = {2'd0, g[2:1], i};
      4'd5: begin
        if (g < 3'd5) row = {1'b0, g};
        else if (g == 3'd5) row = (j == 2'd0) ? 4'd0 : 4'd3;
        else if (g == 3'd6) row = (j == 2'd0) ? 4'd1 : 4'd4;
        else row = (j == 2'd0) ? 4'd2 : ((j == 2'd1) ? 4'd3 : 4'd4);
        a = {row, i};
      end
      4'd6: begin
        if (g < 3'd6) row = {1'b0, g};
        else if (g == 3'd6) row = {2'd0, j};
        else row = 4'd3 + {2'd0, j};
        a = {row, i};
      end
      4'd7, 4'd8: a = {1'b0, s};
      4'd9, 4'd10: begin
        if (j == 2'd0) row = (g[2] ? 4'd5 : 4'd0) + {2'd0, g[1:0]};
        else row = g[2] ? 4'd9 : 4'd4;
        a = {row, i};
      end
      default: a = {s, j[0]};
    endcase
    return a;
  endfunction

  // assemble the raw value of sample s from its bytes
  function automatic logic [15:0] unpack_sample(input logic [3:0] code, input logic [5:0] s,
                                                input logic [7:0] b0, input logic [7:0] b1,
                                                input logic [7:0] b2);
    logic [2:0]  g;
    logic [7:0]  t;
    logic [15:0] v;
    g = s[5:3];
    t = 8'd0;
    v = 16'd0;
    case (code)
      4'd0: v = 16'd0;
      4'd1: v = {15'd0, b0[s[2:0]]};
      4'd2: begin
        t = b0 >> {g[1:0], 1'b0};
        v = {14'd0, t[1:0]};
      end
      4'd3: begin
        case (g)
          3'd0:    v = {13'd0, b0[2:0]};
          3'd1:    v = {13'd0, b0[5:3]};
          3'd2:    v = {13'd0, b2[6], b0[7:6]};
          3'd3:    v = {13'd0, b1[2:0]};
          3'd4:    v = {13'd0, b1[5:3]};
          3'd5:    v = {13'd0, b2[7], b1[7:6]};
          3'd6:    v = {13'd0, b2[2:0]};
          default: v = {13'd0, b2[5:3]};
        endcase
      end
      4'd4: v = g[0] ? {12'd0, b0[7:4]} : {12'd0, b0[3:0]};
      4'd5: begin
        if (g < 3'd5) v = {11'd0, b0[4:0]};
        else if (g == 3'd7) v = {11'd0, b2[7], b1[7], b0[7:5]};
        else v = {11'd0, b1[6:5], b0[7:5]};
      end
      4'd6: begin
        if (g < 3'd6) v = {10'd0, b0[5:0]};
        else v = {10'd0, b2[7:6], b1[7:6], b0[7:6]};
      end
      4'd7, 4'd8: v = {8'd0, b0};
      4'd9, 4'd10: begin
        t = b1 >> {g[1:0], 1'b0};
        v = {6'd0, t[1:0], b0};
      end
      default: v = {b1, b0};
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/rbu_ram.sv -----
// generic single-write, single-read ram with registered read data
module rbu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/rbu_ctrl.sv -----
// controller state machine of the raw block unpacker
`include "raw_block_bit_unpacker_defines.svh"
module rbu_ctrl
  import rbu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  rbu_status_t status,
  output rbu_cmd_t    cmd
);

  rbu_state_t state;
  rbu_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.emit_go) begin
          state_next = ST_RD0;
        end
      end
      ST_RD0: begin
        cmd.rd_phase = 2'd0;
        state_next   = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_phase = 2'd1;
        cmd.cap0     = 1'b1;
        state_next   = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_phase = 2'd2;
        cmd.cap1     = 1'b1;
        state_next   = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = ST_PUT;
      end
      ST_PUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.last_sample) begin
            state_next = ST_LOAD;
          end else begin
            cmd.next_sample = 1'b1;
            state_next      = ST_RD0;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  `RBU_ASSERT_IMP(a_load_free, cmd.out_load, status.out_free, "output word overwritten")
  `RBU_ASSERT_NXT(a_last_back, (state == ST_PUT) && status.out_free && status.last_sample,
                  state == ST_LOAD, "no return to input after last sample")
  `RBU_ASSERT_IMP(a_ready_idle, cmd.accept, in_ready, "item taken while busy")

endmodule

// ----- hw/rtl/rbu_datapath.sv -----
// byte store, sample assembly, offset, shift and output register
`include "raw_block_bit_unpacker_defines.svh"
module rbu_datapath
  import rbu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_opcode,
  input  logic [3:0]  in_code,
  input  logic [15:0] in_ref,
  input  logic [7:0]  in_byte,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_shift,
  input  rbu_cmd_t    cmd,
  output rbu_status_t status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_sample,
  output logic [5:0]  out_index,
  output logic        out_last
);

  logic [4:0]       output_shift;
  logic [3:0]       active_code;
  logic [15:0]      block_offset;
  logic [7:0]       bytes_received;
  logic             block_active;
  logic [5:0]       sample_idx;
  logic [7:0]       b0;
  logic [7:0]       b1;
  logic [15:0]      sum;
  logic [8:0]       bytes_inc;
  logic             hdr;
  logic             ram_we;
  logic [AddrW-1:0] raddr;
  logic [7:0]       ram_q;

  assign hdr       = (in_opcode == OP_HEADER);
  assign bytes_inc = {1'b0, bytes_received} + 9'd1;
  assign ram_we    = cmd.accept && !hdr && block_active;
  assign raddr     = sample_addr(active_code, sample_idx, cmd.rd_phase);

  always_comb begin
    status.emit_go = 1'b0;
    if (hdr) begin
      status.emit_go = (code_len(in_code) == 8'd0);
    end else if (block_active) begin
      status.emit_go = (bytes_inc >= {1'b0, code_len(active_code)});
    end
    status.out_free    = !out_valid || out_ready;
    status.last_sample = (sample_idx == 6'(BlockSamples - 1));
  end

  rbu_ram #(.WIDTH(8), .DEPTH(StoreDepth)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(bytes_received[AddrW-1:0]),
    .wdata(in_byte),
    .raddr(raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      output_shift   <= 5'd0;
      active_code    <= 4'd0;
      block_offset   <= 16'd0;
      bytes_received <= 8'd0;
      block_active   <= 1'b0;
      sample_idx     <= 6'd0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        output_shift <= cfg_shift;
      end
      if (cmd.accept) begin
        if (hdr) begin
          active_code    <= in_code;
          block_offset   <= in_ref;
          bytes_received <= 8'd0;
          block_active   <= !status.emit_go;
        end else if (block_active) begin
          bytes_received <= status.emit_go ? 8'd0 : bytes_inc[7:0];
          block_active   <= !status.emit_go;
        end
        if (status.emit_go) begin
          sample_idx <= 6'd0;
        end
      end
      if (cmd.next_sample) begin
        sample_idx <= sample_idx + 6'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap0) begin
      b0 <= ram_q;
    end
    if (cmd.cap1) begin
      b1 <= ram_q;
    end
    if (cmd.sum_en) begin
      sum <= unpack_sample(active_code, sample_idx, b0, b1, ram_q) + block_offset;
    end
    if (cmd.out_load) begin
      out_sample <= output_shift[4] ? 16'd0 : (sum << output_shift[3:0]);
      out_index  <= sample_idx;
      out_last   <= status.last_sample;
    end
  end

  `RBU_ASSERT_NXT(a_emit_start, cmd.accept && status.emit_go, sample_idx == 6'd0,
                  "block emission does not start at sample zero")
  `RBU_ASSERT_NXT(a_out_set, cmd.out_load, out_valid, "loaded word not presented")
  `RBU_ASSERT_IMP(a_fill_bound, block_active, bytes_received < 8'(StoreDepth),
                  "byte count beyond store")

endmodule

// ----- hw/rtl/raw_block_bit_unpacker.sv -----
// top level of the frame-of-reference raw block unpacker
// usage:
//   s_* carries input words: tuser 0 is a block header (width code and reference
//   in tdata), tuser 1 a payload byte. each word is taken in one cycle while the
//   block is waiting for input.
//   when the last payload byte of a block arrives (or a header with width code
//   zero) input stops and 64 samples come out on m_*, tlast on the final one.
//   each sample goes through three reads of the byte store ram (one read
//   port) plus a sum and an output load; the next sample starts after that
//   load. a stalled receiver holds the output word; the sequencer waits on
//   it and then continues. input is taken again as soon as the last word is
//   loaded, while that word may still be waiting.
//   cfg_* writes the output shift and is always ready; the user writes it
//   only while the block is idle, which the block itself does not enforce.
//   reset clears the shift, the open block and the output valid; the byte store
//   is not cleared and needs no clearing pass.
module raw_block_bit_unpacker
  import rbu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // width_code[3:0], reference_value[19:4], data_byte[27:20]
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // sample[15:0], sample_index[21:16]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  rbu_cmd_t    cmd;
  rbu_status_t status;
  logic [15:0] sample;
  logic [5:0]  sample_index;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {2'b00, sample_index, sample};

  rbu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  rbu_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_opcode (s_tuser),
    .in_code   (s_tdata[3:0]),
    .in_ref    (s_tdata[19:4]),
    .in_byte   (s_tdata[27:20]),
    .cfg_we    (cfg_valid),
    .cfg_shift (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_sample(sample),
    .out_index (sample_index),
    .out_last  (m_tlast)
  );

endmodule

// ----- verif/tb_raw_block_bit_unpacker.sv -----
// self-checking testbench of the raw block unpacker: directed and random blocks
module tb_raw_block_bit_unpacker;
  import rbu_pkg::*;

  typedef struct packed {
    logic        op;
    logic [3:0]  code;
    logic [15:0] refv;
    logic [7:0]  data;
  } in_word_t;

  typedef struct packed {
    logic [15:0] sample;
    logic [5:0]  index;
    logic        last;
  } out_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  raw_block_bit_unpacker u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_word_t  pending_words[$];
  out_word_t expected_samples[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      hold_go = 1'b0;
  logic      hold_active = 1'b0;

  // decoder state mirrored here
  logic [4:0]  shift_amt = '0;
  logic [3:0]  cur_code = '0;
  logic [15:0] cur_ref = '0;
  int          byte_count = 0;
  logic        open_block = 1'b0;
  logic [7:0]  block_bytes[128];

  function automatic int block_len(logic [3:0] c);
    case (c)
      4'd0: return 0;
      4'd1: return 8;
      4'd2: return 16;
      4'd3: return 24;
      4'd4: return 32;
      4'd5: return 40;
      4'd6: return 48;
      4'd7, 4'd8: return 64;
      4'd9, 4'd10: return 80;
      default: return 128;
    endcase
  endfunction

  task automatic report(string what, int idx, int got, int exp_v);
    $display("mismatch %s at sample %0d: got %0h expected %0h", what, idx, got, exp_v);
    mismatches++;
  endtask

  task automatic queue_block_samples();
    logic [15:0] v[64];
    logic [7:0]  p[6];
    logic [15:0] s;
    out_word_t   o;
    for (int k = 0; k < 64; k++) v[k] = '0;
    case (cur_code)
      4'd0: ;
      4'd1: for (int k = 0; k < 64; k++) v[k] = 16'((block_bytes[k >> 3] >> (k & 7)) & 1);
      4'd2:
        for (int i = 0; i < 16; i++)
          for (int k = 0; k < 4; k++)
            v[(i >> 3) * 32 + (i & 7) + 8 * k] = 16'((block_bytes[i] >> (2 * k)) & 3);
      4'd3:
        for (int i = 0; i < 8; i++) begin
          p[0] = block_bytes[i]; p[1] = block_bytes[8 + i]; p[2] = block_bytes[16 + i];
          v[i]      = 16'(p[0] & 7);
          v[i + 8]  = 16'((p[0] >> 3) & 7);
          v[i + 16] = 16'(((p[0] >> 6) & 3) | (((p[2] >> 6) & 1) << 2));
          v[i + 24] = 16'(p[1] & 7);
          v[i + 32] = 16'((p[1] >> 3) & 7);
          v[i + 40] = 16'(((p[1] >> 6) & 3) | (((p[2] >> 7) & 1) << 2));
          v[i + 48] = 16'(p[2] & 7);
          v[i + 56] = 16'((p[2] >> 3) & 7);
        end
      4'd4:
        for (int i = 0; i < 32; i++) begin
          v[(i >> 3) * 16 + (i & 7)]     = 16'(block_bytes[i] & 8'h0F);
          v[(i >> 3) * 16 + (i & 7) + 8] = 16'(block_bytes[i] >> 4);
        end
      4'd5:
        for (int i = 0; i < 8; i++) begin
          for (int k = 0; k < 5; k++) begin
            p[k] = block_bytes[8 * k + i];
            v[i + 8 * k] = 16'(p[k] & 8'h1F);
          end
          v[i + 40] = 16'(((p[0] >> 5) & 7) | (((p[3] >> 5) & 3) << 3));
          v[i + 48] = 16'(((p[1] >> 5) & 7) | (((p[4] >> 5) & 3) << 3));
          v[i + 56] = 16'(((p[2] >> 5) & 7) | (((p[3] >> 7) & 1) << 3)
                          | (((p[4] >> 7) & 1) << 4));
        end
      4'd6:
        for (int i = 0; i < 8; i++) begin
          for (int k = 0; k < 6; k++) begin
            p[k] = block_bytes[8 * k + i];
            v[i + 8 * k] = 16'(p[k] & 8'h3F);
          end
          v[i + 48] = 16'(((p[0] >> 6) & 3) | (((p[1] >> 6) & 3) << 2)
                          | (((p[2] >> 6) & 3) << 4));
          v[i + 56] = 16'(((p[3] >> 6) & 3) | (((p[4] >> 6) & 3) << 2)
                          | (((p[5] >> 6) & 3) << 4));
        end
      4'd7, 4'd8: for (int k = 0; k < 64; k++) v[k] = 16'(block_bytes[k]);
      4'd9, 4'd10:
        for (int i = 0; i < 8; i++)
          for (int h = 0; h < 2; h++)
            for (int k = 0; k < 4; k++)
              v[i + 8 * (4 * h + k)] = {6'd0,
                2'((block_bytes[8 * (5 * h + 4) + i] >> (2 * k)) & 3),
                block_bytes[8 * (5 * h + k) + i]};
      default:
        for (int k = 0; k < 64; k++) v[k] = {block_bytes[2 * k + 1], block_bytes[2 * k]};
    endcase
    for (int k = 0; k < 64; k++) begin
      s = v[k] + cur_ref;
      o.sample = (shift_amt >= 16) ? 16'd0 : s << shift_amt;
      o.index  = 6'(k);
      o.last   = (k == 63);
      expected_samples.push_back(o);
    end
    open_block = 1'b0;
    byte_count = 0;
  endtask

  task automatic predict_word(in_word_t w);
    if (w.op == OP_HEADER) begin
      cur_code = w.code;
      cur_ref = w.refv;
      byte_count = 0;
      open_block = 1'b1;
      if (block_len(cur_code) == 0) queue_block_samples();
    end else if (open_block) begin
      block_bytes[byte_count] = w.data;
      byte_count++;
      if (byte_count >= block_len(cur_code)) queue_block_samples();
    end
  endtask

  function automatic in_word_t header(logic [3:0] c, logic [15:0] r);
    in_word_t w;
    w.op = OP_HEADER; w.code = c; w.refv = r; w.data = 8'($urandom);
    return w;
  endfunction

  function automatic in_word_t payload(logic [7:0] d);
    in_word_t w;
    w.op = OP_PAYLOAD; w.code = 4'($urandom); w.refv = 16'($urandom); w.data = d;
    return w;
  endfunction

  task automatic add_block(logic [3:0] c, logic [15:0] r, int fill_kind);
    pending_words.push_back(header(c, r));
    for (int i = 0; i < block_len(c); i++)
      case (fill_kind)
        0: pending_words.push_back(payload(8'h00));
        1: pending_words.push_back(payload(8'hFF));
        default: pending_words.push_back(payload(8'($urandom)));
      endcase
  endtask

  // driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_words.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_word_t w;
        w = pending_words.pop_front();
        predict_word(w);
        s_tvalid <= 1'b1;
        s_tuser  <= w.op;
        s_tdata  <= {4'd0, w.data, w.refv, w.code};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver readiness and check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      out_word_t e;
      if (expected_samples.size() == 0) begin
        report("unexpected", int'(m_tdata[21:16]), int'(m_tdata[15:0]), 0);
      end else begin
        e = expected_samples.pop_front();
        if (m_tdata[15:0] !== e.sample)
          report("sample", int'(e.index), int'(m_tdata[15:0]), int'(e.sample));
        if (m_tdata[21:16] !== e.index)
          report("index", int'(e.index), int'(m_tdata[21:16]), int'(e.index));
        if (m_tlast !== e.last)
          report("tlast", int'(e.index), int'(m_tlast), int'(e.last));
      end
    end
    if (hold_active) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // long receiver hold-off while the sender keeps offering words
  initial begin
    wait (hold_go);
    hold_active <= 1'b1;
    repeat (2000) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    if (cycle_count > 3000000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic drain();
    while (pending_words.size() > 0 || s_tvalid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_shift(logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shift_amt = value;
  endtask

  initial begin
    logic [3:0] c;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty block at the top reference, then a stray byte with no open block
    add_block(4'd0, 16'hFFFF, 2);
    pending_words.push_back(payload(8'hA5));
    // header mid-block drops partial block
    pending_words.push_back(header(4'd4, 16'h1234));
    pending_words.push_back(payload(8'h5A));
    add_block(4'd1, 16'hFFF0, 1);
    drain();

    set_shift(5'd16);
    add_block(4'd0, 16'h00FF, 2);
    drain();
    set_shift(5'd31);
    add_block(4'd1, 16'h8000, 2);
    drain();
    set_shift(5'd15);
    // long receiver hold-off so the block backs up its input
    hold_go = 1'b1;
    add_block(4'd3, 16'h0003, 2);
    add_block(4'd0, 16'h0002, 2);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      set_shift(5'($urandom_range(16, 0)));
      send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 26 : 77) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 26 : 77) : 0;
      if ($urandom_range(9, 0) == 0) begin
        pending_words.push_back(header(4'($urandom), 16'($urandom)));
        for (int i = $urandom_range(5, 0); i > 0; i--)
          pending_words.push_back(payload(8'($urandom)));
      end
      // a narrow block each phase, one wider block in the last
      c = 4'($urandom_range(5, 0));
      add_block(c, 16'($urandom), 2);
      if (phase == 3) begin
        c = 4'($urandom_range(11, 6));
        add_block(c, 16'($urandom), 2);
      end
      if ($urandom_range(9, 0) == 0) pending_words.push_back(payload(8'($urandom)));
      drain();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
